>>> hdl/ptcd_pkg.sv
// ----------------------------------------------------------------------------
// ptcd_pkg
// Types, register map and constants shared by the pointer tracker and click
// detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ptcd_pkg;

    localparam int NUM_BUTTONS = 5;
    localparam int COORD_BITS  = 12;

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    // register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MAX_X           = 3'd0;
    localparam logic [2:0] REG_MAX_Y           = 3'd1;
    localparam logic [2:0] REG_MIN_MOVE        = 3'd2;
    localparam logic [2:0] REG_ACTIVE_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_DOUBLE_CLICK    = 3'd4;
    localparam logic [2:0] REG_ENABLED         = 3'd5;

    localparam logic [COORD_BITS-1:0] MAX_X_RESET = COORD_BITS'(720);
    localparam logic [COORD_BITS-1:0] MAX_Y_RESET = COORD_BITS'(576);
    localparam logic [7:0]            MIN_MOVE_RESET = 8'd2;
    localparam logic [31:0]           ACTIVE_TIMEOUT_RESET = 32'd5000;
    localparam logic [31:0]           DOUBLE_CLICK_RESET   = 32'd500;

    localparam logic [COORD_BITS-1:0] CUR_X_RESET = COORD_BITS'(360);
    localparam logic [COORD_BITS-1:0] CUR_Y_RESET = COORD_BITS'(288);

    localparam logic CMD_POINTER = 1'b0;
    localparam logic CMD_WHEEL   = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] max_y;
        logic [15:0]           min_move_sq;
        logic [31:0]           active_timeout_ms;
        logic [31:0]           double_click_ms;
        logic                  enabled;
    } cfg_t;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] event_x;
        logic signed [15:0] event_y;
        logic [2:0]         button_code;
        logic               button_down;
        logic signed [7:0]  wheel_dir;
        logic [31:0]        now_ms;
    } in_item_t;

    typedef struct packed {
        logic [COORD_BITS-1:0]  pos_x;
        logic [COORD_BITS-1:0]  pos_y;
        logic signed [7:0]      delta_x;
        logic signed [7:0]      delta_y;
        logic signed [7:0]      wheel;
        logic                   is_active;
        logic [NUM_BUTTONS-1:0] click_mask;
        logic [NUM_BUTTONS-1:0] double_click_mask;
        logic [NUM_BUTTONS-1:0] hold_mask;
        logic                   all_released;
    } out_item_t;

endpackage

`default_nettype wire

>>> hdl/ptcd_regs.sv
// ----------------------------------------------------------------------------
// ptcd_regs
// APB-style configuration registers. Also keeps min_move squared so the
// movement threshold needs no multiplier in the event path.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcd_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptcd_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [ptcd_pkg::DATA_BITS-1:0] pwdata,
    output logic      [ptcd_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready,
    output ptcd_pkg::cfg_t                      cfg
);
    import ptcd_pkg::*;

    logic [COORD_BITS-1:0] max_x_reg;
    logic [COORD_BITS-1:0] max_y_reg;
    logic [7:0]            min_move_reg;
    logic [15:0]           min_move_sq_reg;
    logic [31:0]           active_timeout_reg;
    logic [31:0]           double_click_reg;
    logic                  enabled_reg;

    logic       wr_en;
    logic [2:0] reg_index;
    logic [15:0] wdata_sq;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[ADDR_BITS-1:2];
    assign wdata_sq  = 16'(pwdata[7:0]) * 16'(pwdata[7:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_x_reg          <= MAX_X_RESET;
            max_y_reg          <= MAX_Y_RESET;
            min_move_reg       <= MIN_MOVE_RESET;
            min_move_sq_reg    <= 16'(MIN_MOVE_RESET) * 16'(MIN_MOVE_RESET);
            active_timeout_reg <= ACTIVE_TIMEOUT_RESET;
            double_click_reg   <= DOUBLE_CLICK_RESET;
            enabled_reg        <= 1'b1;
        end
        else if (wr_en)
        begin
            case (reg_index)
                REG_MAX_X:          max_x_reg <= COORD_BITS'(pwdata[11:0]);
                REG_MAX_Y:          max_y_reg <= COORD_BITS'(pwdata[11:0]);
                REG_MIN_MOVE:
                begin
                    min_move_reg    <= pwdata[7:0];
                    min_move_sq_reg <= wdata_sq;
                end
                REG_ACTIVE_TIMEOUT: active_timeout_reg <= pwdata;
                REG_DOUBLE_CLICK:   double_click_reg   <= pwdata;
                REG_ENABLED:        enabled_reg        <= pwdata[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_MAX_X:          prdata = DATA_BITS'(max_x_reg);
            REG_MAX_Y:          prdata = DATA_BITS'(max_y_reg);
            REG_MIN_MOVE:       prdata = DATA_BITS'(min_move_reg);
            REG_ACTIVE_TIMEOUT: prdata = active_timeout_reg;
            REG_DOUBLE_CLICK:   prdata = double_click_reg;
            REG_ENABLED:        prdata = DATA_BITS'(enabled_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.max_x             = max_x_reg;
    assign cfg.max_y             = max_y_reg;
    assign cfg.min_move_sq       = min_move_sq_reg;
    assign cfg.active_timeout_ms = active_timeout_reg;
    assign cfg.double_click_ms   = double_click_reg;
    assign cfg.enabled           = enabled_reg;

endmodule

`default_nettype wire

>>> hdl/ptcd_core.sv
// ----------------------------------------------------------------------------
// ptcd_core
// Pointer and button state, and the single-pass update for one event.
// The result is combinational on the held event; state commits on step.
// ----------------------------------------------------------------------------
`default_nettype none

module ptcd_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire ptcd_pkg::in_item_t  item,
    input  wire ptcd_pkg::cfg_t      cfg,
    output ptcd_pkg::out_item_t      result
);
    import ptcd_pkg::*;

    logic [COORD_BITS-1:0]  cur_x_reg, cur_x_next;
    logic [COORD_BITS-1:0]  cur_y_reg, cur_y_next;
    logic [7:0]             dx_reg, dx_next;
    logic [7:0]             dy_reg, dy_next;
    logic [7:0]             wheel_reg, wheel_next;
    logic                   active_reg, active_next;
    logic [31:0]            last_active_reg, last_active_next;
    logic [31:0]            release_time_reg [NUM_BUTTONS];
    logic [31:0]            release_time_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] was_down_reg, was_down_next;

    logic [16:0]            diff_x, diff_y;
    logic                   moved;
    logic [COORD_BITS-1:0]  clamp_x, clamp_y;
    logic [15:0]            sq_x, sq_y;
    logic [16:0]            dist_sq;
    logic                   far_enough;
    logic                   timed_out;
    logic                   act_move;
    logic [31:0]            lat_move;
    logic [NUM_BUTTONS-1:0] pressed;
    logic [NUM_BUTTONS-1:0] clk_mask, dbl_mask, hold_mask;
    logic                   is_wheel;

    assign is_wheel = (item.cmd == CMD_WHEEL);

    // old minus new, in 17 bits so equality is exact
    assign diff_x = 17'(cur_x_reg) - 17'(item.event_x);
    assign diff_y = 17'(cur_y_reg) - 17'(item.event_y);
    assign moved  = (diff_x != 17'd0) || (diff_y != 17'd0);

    always_comb
    begin
        if (item.event_x[15])
            clamp_x = '0;
        else if (item.event_x[14:0] > 15'(cfg.max_x))
            clamp_x = cfg.max_x;
        else
            clamp_x = item.event_x[COORD_BITS-1:0];

        if (item.event_y[15])
            clamp_y = '0;
        else if (item.event_y[14:0] > 15'(cfg.max_y))
            clamp_y = cfg.max_y;
        else
            clamp_y = item.event_y[COORD_BITS-1:0];
    end

    // operands sign-extended to 16 bits; the largest square is 16384
    assign sq_x       = 16'($signed(diff_x[7:0])) * 16'($signed(diff_x[7:0]));
    assign sq_y       = 16'($signed(diff_y[7:0])) * 16'($signed(diff_y[7:0]));
    assign dist_sq    = 17'(sq_x) + 17'(sq_y);
    assign far_enough = (dist_sq >= 17'(cfg.min_move_sq));
    assign timed_out  = ((item.now_ms - last_active_reg) > cfg.active_timeout_ms);

    always_comb
    begin
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            pressed[i] = item.button_down && (item.button_code == 3'(i + 1));
        end
    end

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        wheel_next       = wheel_reg;
        active_next      = active_reg;
        last_active_next = last_active_reg;
        was_down_next    = was_down_reg;
        clk_mask         = '0;
        dbl_mask         = '0;
        hold_mask        = '0;
        act_move         = active_reg;
        lat_move         = last_active_reg;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            release_time_next[i] = release_time_reg[i];
        end

        if (is_wheel)
        begin
            wheel_next       = item.wheel_dir;
            active_next      = 1'b1;
            last_active_next = item.now_ms;
        end
        else
        begin
            if (moved)
            begin
                dx_next    = diff_x[7:0];
                dy_next    = diff_y[7:0];
                cur_x_next = clamp_x;
                cur_y_next = clamp_y;
                if (far_enough)
                begin
                    act_move = 1'b1;
                    lat_move = item.now_ms;
                end
            end
            else
            begin
                dx_next    = '0;
                dy_next    = '0;
                wheel_next = '0;
                if (timed_out)
                    act_move = 1'b0;
            end

            // a press wakes an inactive pointer
            active_next      = act_move || (|pressed);
            last_active_next = ((|pressed) && !act_move) ? item.now_ms : lat_move;

            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                if (pressed[i])
                begin
                    if (was_down_reg[i])
                        hold_mask[i] = 1'b1;
                    else if ((item.now_ms - release_time_reg[i]) < cfg.double_click_ms)
                        dbl_mask[i] = 1'b1;
                end
                else if (was_down_reg[i])
                begin
                    clk_mask[i]          = 1'b1;
                    release_time_next[i] = item.now_ms;
                end
            end
            was_down_next = pressed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= CUR_X_RESET;
            cur_y_reg       <= CUR_Y_RESET;
            dx_reg          <= '0;
            dy_reg          <= '0;
            wheel_reg       <= '0;
            active_reg      <= 1'b1;
            last_active_reg <= '0;
            was_down_reg    <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                release_time_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            dx_reg          <= dx_next;
            dy_reg          <= dy_next;
            wheel_reg       <= wheel_next;
            active_reg      <= active_next;
            last_active_reg <= last_active_next;
            was_down_reg    <= was_down_next;
            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                release_time_reg[i] <= release_time_next[i];
            end
        end
    end

    assign result.pos_x             = cur_x_next;
    assign result.pos_y             = cur_y_next;
    assign result.delta_x           = dx_next;
    assign result.delta_y           = dy_next;
    assign result.wheel             = wheel_next;
    assign result.is_active         = active_next && cfg.enabled;
    assign result.click_mask        = clk_mask;
    assign result.double_click_mask = dbl_mask;
    assign result.hold_mask         = hold_mask;
    assign result.all_released      = is_wheel || ((pressed | was_down_reg) == '0);

endmodule

`default_nettype wire

>>> hdl/pointer_tracker_click_detector.sv
// ----------------------------------------------------------------------------
// pointer_tracker_click_detector
// Pointer position, movement, wheel and activity tracking with per-button
// click, double-click and hold detection from timestamped events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------
//  in      | input     | in_valid / in_stall    | in_data  (in_item_t)
//  out     | output    | out_valid / out_stall  | out_data (out_item_t)
//  apb     | input     | psel/penable/pready    | paddr, pwdata, prdata
//
//  One event per cycle sustained while out does not stall. An event is held in
//  the input register, then its result lands in the output register. Reset
//  clears the pointer state to the power-on position and all buttons up. A
//  stall on out holds the result and backs up into in_stall in the same
//  cycle; no transfer is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module pointer_tracker_click_detector (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire ptcd_pkg::in_item_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output ptcd_pkg::out_item_t                 out_data,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ptcd_pkg::ADDR_BITS-1:0] paddr,
    input  wire logic [ptcd_pkg::DATA_BITS-1:0] pwdata,
    output logic      [ptcd_pkg::DATA_BITS-1:0] prdata,
    output logic                                pready
);
    import ptcd_pkg::*;

    cfg_t      cfg;
    in_item_t  item_reg;
    logic      item_valid_reg;
    out_item_t result;
    out_item_t result_reg;
    logic      result_valid_reg;
    logic      advance;
    logic      step;

    // the held event moves on whenever the output register is free or drains
    assign advance  = !result_valid_reg || !out_stall;
    assign step     = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (!in_stall)
            item_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (advance)
            result_valid_reg <= item_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= result;
    end

    assign out_valid = result_valid_reg;
    assign out_data  = result_reg;

    ptcd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ptcd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pointer_tracker_click_detector. A directed table of
// pointer, wheel and button events runs first, then six phases of random
// event streams under different register settings. Every result is compared
// field by field against an in-bench tracker of position, activity and button
// history, with random idle cycles on both sides of the block.
// ----------------------------------------------------------------------------

module testbench;

    import ptcd_pkg::*;

    localparam logic [2:0] BTN_NONE     = 3'd0;
    localparam logic [2:0] BTN_LEFT     = 3'd1;
    localparam logic [2:0] BTN_RIGHT    = 3'd2;
    localparam logic [2:0] BTN_MIDDLE   = 3'd3;
    localparam logic [2:0] BTN_EXTRA1   = 3'd4;
    localparam logic [2:0] BTN_EXTRA2   = 3'd5;
    localparam logic [2:0] BTN_UNUSED_A = 3'd6;
    localparam logic [2:0] BTN_UNUSED_B = 3'd7;

    // no register decodes here
    localparam logic [2:0] REG_UNMAPPED = 3'd6;

    localparam int PHASES       = 6;
    localparam int PHASE_EVENTS = 240;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_item_t            out_data;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_BITS-1:0] paddr     = '0;
    logic [DATA_BITS-1:0] pwdata    = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    pointer_tracker_click_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // tracker copy of the register file
    logic [COORD_BITS-1:0] lim_x    = MAX_X_RESET;
    logic [COORD_BITS-1:0] lim_y    = MAX_Y_RESET;
    logic [7:0]            move_min = MIN_MOVE_RESET;
    logic [31:0]           idle_ms  = ACTIVE_TIMEOUT_RESET;
    logic [31:0]           dbl_ms   = DOUBLE_CLICK_RESET;
    bit                    en       = 1'b1;

    // tracker copy of the pointer state
    logic [COORD_BITS-1:0]  trk_x           = CUR_X_RESET;
    logic [COORD_BITS-1:0]  trk_y           = CUR_Y_RESET;
    logic signed [7:0]      trk_dx          = '0;
    logic signed [7:0]      trk_dy          = '0;
    logic signed [7:0]      trk_wheel       = '0;
    bit                     trk_active      = 1'b1;
    logic [31:0]            trk_last_active = '0;
    logic [31:0]            trk_release_ms [NUM_BUTTONS] = '{default: '0};
    bit [NUM_BUTTONS-1:0]   trk_down        = '0;

    out_item_t reports_due[$];

    in_item_t  dir_events[$];
    bit        dir_typed[$];
    out_item_t dir_want[$];

    int send_idle_pct = 11;
    int recv_idle_pct = 74;

    int n_events   = 0;
    int n_reports  = 0;
    int n_writes   = 0;
    int n_errors   = 0;
    int n_clicks   = 0;
    int n_doubles  = 0;
    int n_holds    = 0;
    int n_inactive = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("t=%0t ns: run did not finish in time", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic logic [COORD_BITS-1:0] coord_limit(input logic signed [15:0] v,
                                                          input logic [COORD_BITS-1:0] hi);
        if (v < 0)
            return '0;
        if (int'(v) > int'(hi))
            return hi;
        return v[COORD_BITS-1:0];
    endfunction

    // Advance the tracked pointer by one event and return the report it gives.
    function automatic out_item_t track_pointer(input in_item_t ev);
        out_item_t            rpt;
        int                   fx;
        int                   fy;
        bit                   pressed;
        bit                   quiet;
        logic [NUM_BUTTONS-1:0] clk_m;
        logic [NUM_BUTTONS-1:0] dbl_m;
        logic [NUM_BUTTONS-1:0] hold_m;

        clk_m  = '0;
        dbl_m  = '0;
        hold_m = '0;
        quiet  = 1'b1;

        if (ev.cmd == CMD_WHEEL)
        begin
            trk_wheel       = ev.wheel_dir;
            trk_active      = 1'b1;
            trk_last_active = ev.now_ms;
        end
        else
        begin
            fx = int'(trk_x) - int'(ev.event_x);
            fy = int'(trk_y) - int'(ev.event_y);
            if (fx != 0 || fy != 0)
            begin
                trk_dx = 8'(fx);
                trk_dy = 8'(fy);
                trk_x  = coord_limit(ev.event_x, lim_x);
                trk_y  = coord_limit(ev.event_y, lim_y);
                if (int'(trk_dx) * int'(trk_dx) + int'(trk_dy) * int'(trk_dy)
                    >= int'(move_min) * int'(move_min))
                begin
                    trk_active      = 1'b1;
                    trk_last_active = ev.now_ms;
                end
            end
            else
            begin
                trk_dx    = '0;
                trk_dy    = '0;
                trk_wheel = '0;
                if ((ev.now_ms - trk_last_active) > idle_ms)
                    trk_active = 1'b0;
            end

            for (int i = 0; i < NUM_BUTTONS; i++)
            begin
                pressed = ev.button_down && (ev.button_code == 3'(i + 1));
                if (pressed)
                begin
                    if (!trk_active)
                    begin
                        trk_active      = 1'b1;
                        trk_last_active = ev.now_ms;
                    end
                    quiet = 1'b0;
                    if (trk_down[i])
                        hold_m[i] = 1'b1;
                    else if ((ev.now_ms - trk_release_ms[i]) < dbl_ms)
                        dbl_m[i] = 1'b1;
                end
                else if (trk_down[i])
                begin
                    quiet             = 1'b0;
                    clk_m[i]          = 1'b1;
                    trk_release_ms[i] = ev.now_ms;
                end
                trk_down[i] = pressed;
            end
        end

        rpt.pos_x             = trk_x;
        rpt.pos_y             = trk_y;
        rpt.delta_x           = trk_dx;
        rpt.delta_y           = trk_dy;
        rpt.wheel             = trk_wheel;
        rpt.is_active         = trk_active & en;
        rpt.click_mask        = clk_m;
        rpt.double_click_mask = dbl_m;
        rpt.hold_mask         = hold_m;
        rpt.all_released      = quiet;
        return rpt;
    endfunction

    // report with the pointer parked and no button activity
    function automatic out_item_t idle_result(input int x, input int y, input int whl);
        out_item_t rpt;
        rpt                   = '0;
        rpt.pos_x             = COORD_BITS'(x);
        rpt.pos_y             = COORD_BITS'(y);
        rpt.wheel             = 8'(whl);
        rpt.is_active         = 1'b1;
        rpt.all_released      = 1'b1;
        return rpt;
    endfunction

    task automatic add_row(input logic cmd, input int x, input int y, input logic [2:0] code,
                           input logic down, input int whl, input logic [31:0] ms,
                           input bit typed, input out_item_t want);
        in_item_t ev;
        ev             = '0;
        ev.cmd         = cmd;
        ev.event_x     = 16'(x);
        ev.event_y     = 16'(y);
        ev.button_code = code;
        ev.button_down = down;
        ev.wheel_dir   = 8'(whl);
        ev.now_ms      = ms;
        dir_events.push_back(ev);
        dir_typed.push_back(typed);
        dir_want.push_back(want);
    endtask

    task automatic send_event(input in_item_t ev, input bit typed, input out_item_t want);
        out_item_t pred;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do
            @(posedge clk);
        while (in_stall);
        pred = track_pointer(ev);
        reports_due.push_back(typed ? want : pred);
        n_events++;
    endtask

    // hold off the input until every outstanding report is back
    task automatic settle();
        in_valid <= 1'b0;
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MAX_X:          lim_x    = value[COORD_BITS-1:0];
            REG_MAX_Y:          lim_y    = value[COORD_BITS-1:0];
            REG_MIN_MOVE:       move_min = value[7:0];
            REG_ACTIVE_TIMEOUT: idle_ms  = value;
            REG_DOUBLE_CLICK:   dbl_ms   = value;
            REG_ENABLED:        en       = value[0];
            default:            ;
        endcase
        n_writes++;
        @(posedge clk);
    endtask

    task automatic report_field(input string fld, input int want, input int got);
        if (want != got)
        begin
            if (n_errors < 40)
                $display("t=%0t ns: %s expected %0d got %0d", $time, fld, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reports_due.size() == 0)
            begin
                $display("t=%0t ns: unexpected transfer, expected none got %h",
                         $time, out_data);
                n_errors++;
            end
            else
            begin
                want = reports_due.pop_front();
                report_field("pos_x", want.pos_x, out_data.pos_x);
                report_field("pos_y", want.pos_y, out_data.pos_y);
                report_field("delta_x", want.delta_x, out_data.delta_x);
                report_field("delta_y", want.delta_y, out_data.delta_y);
                report_field("wheel", want.wheel, out_data.wheel);
                report_field("is_active", want.is_active, out_data.is_active);
                report_field("click_mask", want.click_mask, out_data.click_mask);
                report_field("double_click_mask", want.double_click_mask,
                             out_data.double_click_mask);
                report_field("hold_mask", want.hold_mask, out_data.hold_mask);
                report_field("all_released", want.all_released, out_data.all_released);
                n_reports++;
                n_clicks   += $countones(want.click_mask);
                n_doubles  += $countones(want.double_click_mask);
                n_holds    += $countones(want.hold_mask);
                n_inactive += want.is_active ? 0 : 1;
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    initial
    begin : stimulus
        in_item_t    ev;
        logic [31:0] stamp;
        logic [31:0] dt;
        logic [2:0]  pick_code;
        int          sel;

        stamp     = 32'd10000;
        pick_code = BTN_NONE;

        // parked pointer and wheel extremes
        add_row(CMD_WHEEL, 0, 0, BTN_NONE, 1'b0, 127, 32'd10, 1'b1, idle_result(360, 288, 127));
        add_row(CMD_WHEEL, 0, 0, BTN_NONE, 1'b0, -128, 32'd20, 1'b1,
                idle_result(360, 288, -128));
        add_row(CMD_POINTER, 360, 288, BTN_NONE, 1'b0, 0, 32'd30, 1'b1,
                idle_result(360, 288, 0));
        // coordinate extremes, clamped at both ends
        add_row(CMD_POINTER, -32768, -32768, BTN_NONE, 1'b0, 0, 32'd40, 1'b0, '0);
        add_row(CMD_POINTER, 32767, 32767, BTN_NONE, 1'b0, 0, 32'd50, 1'b0, '0);
        // press, click, double click, hold, release by an up event
        add_row(CMD_POINTER, 100, 100, BTN_LEFT, 1'b1, 0, 32'd1000, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_NONE, 1'b0, 0, 32'd1100, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_LEFT, 1'b1, 0, 32'd1200, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_LEFT, 1'b1, 0, 32'd1300, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_LEFT, 1'b0, 0, 32'd1400, 1'b0, '0);
        // walk through the other buttons and the codes with no button
        add_row(CMD_POINTER, 100, 100, BTN_RIGHT, 1'b1, 0, 32'd1500, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_MIDDLE, 1'b1, 0, 32'd1600, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_UNUSED_A, 1'b1, 0, 32'd1700, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_UNUSED_B, 1'b1, 0, 32'd1800, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_EXTRA1, 1'b1, 0, 32'd1900, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_EXTRA2, 1'b1, 0, 32'd2000, 1'b0, '0);
        add_row(CMD_POINTER, 100, 100, BTN_NONE, 1'b1, 0, 32'd2100, 1'b0, '0);
        // one-pixel nudge below min_move, then idle past the timeout
        add_row(CMD_POINTER, 101, 100, BTN_NONE, 1'b0, 0, 32'd2150, 1'b0, '0);
        add_row(CMD_POINTER, 101, 100, BTN_NONE, 1'b0, 0, 32'd7000, 1'b0, '0);
        add_row(CMD_POINTER, 101, 100, BTN_LEFT, 1'b1, 0, 32'd7100, 1'b0, '0);
        add_row(CMD_POINTER, 101, 100, BTN_NONE, 1'b0, 0, 32'd7200, 1'b0, '0);
        // double click across the timer wrap
        add_row(CMD_WHEEL, 0, 0, BTN_NONE, 1'b0, 1, 32'hFFFF_FF00, 1'b0, '0);
        add_row(CMD_POINTER, 101, 100, BTN_LEFT, 1'b1, 0, 32'hFFFF_FF80, 1'b0, '0);
        add_row(CMD_POINTER, 101, 100, BTN_NONE, 1'b0, 0, 32'hFFFF_FFF0, 1'b0, '0);
        add_row(CMD_POINTER, 101, 100, BTN_LEFT, 1'b1, 0, 32'h0000_0010, 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_events[k])
            send_event(dir_events[k], dir_typed[k], dir_want[k]);

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    // junk in the upper data bits must be dropped
                    reg_write(REG_MAX_X, 32'hABCD_E2D0);
                    reg_write(REG_MAX_Y, 32'h5555_5240);
                    reg_write(REG_MIN_MOVE, 32'hFFFF_FF02);
                    reg_write(REG_ACTIVE_TIMEOUT, 32'd5000);
                    reg_write(REG_DOUBLE_CLICK, 32'd500);
                    reg_write(REG_ENABLED, 32'hFFFF_FFFF);
                end
                1:
                begin
                    reg_write(REG_MAX_X, 32'd0);
                    reg_write(REG_MAX_Y, 32'd0);
                    reg_write(REG_MIN_MOVE, 32'd0);
                    reg_write(REG_ACTIVE_TIMEOUT, 32'd0);
                    reg_write(REG_DOUBLE_CLICK, 32'd0);
                    reg_write(REG_ENABLED, 32'd0);
                    reg_write(REG_UNMAPPED, $urandom);
                end
                2:
                begin
                    reg_write(REG_MAX_X, 32'd4095);
                    reg_write(REG_MAX_Y, 32'd4095);
                    reg_write(REG_MIN_MOVE, 32'd255);
                    reg_write(REG_ACTIVE_TIMEOUT, 32'hFFFF_FFFF);
                    reg_write(REG_DOUBLE_CLICK, 32'hFFFF_FFFF);
                    reg_write(REG_ENABLED, 32'd1);
                end
                3, 4:
                begin
                    reg_write(REG_MAX_X, $urandom_range(1, 4095));
                    reg_write(REG_MAX_Y, $urandom_range(1, 4095));
                    reg_write(REG_MIN_MOVE, $urandom_range(0, 8));
                    reg_write(REG_ACTIVE_TIMEOUT, $urandom_range(20, 600));
                    reg_write(REG_DOUBLE_CLICK, $urandom_range(10, 300));
                    reg_write(REG_ENABLED, (p == 4) ? $urandom_range(0, 1) : 32'd1);
                end
                default:
                begin
                    reg_write(REG_MAX_X, 32'd4095);
                    reg_write(REG_MAX_Y, 32'd4095);
                    reg_write(REG_MIN_MOVE, 32'd1);
                    reg_write(REG_ACTIVE_TIMEOUT, 32'd300);
                    reg_write(REG_DOUBLE_CLICK, 32'd250);
                    reg_write(REG_ENABLED, 32'd1);
                    stamp = 32'hFFFF_FF00;
                end
            endcase

            if (p < 2)
            begin
                send_idle_pct = 11;
                recv_idle_pct = 74;
            end
            else if (p < 4)
            begin
                send_idle_pct = 74;
                recv_idle_pct = 11;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int n = 0; n < PHASE_EVENTS; n++)
            begin
                if (n == PHASE_EVENTS / 2)
                    settle();

                // mostly short steps so double-click and timeout windows get hit
                sel = $urandom_range(0, 99);
                if (sel < 80)
                    dt = $urandom_range(0, 300);
                else if (sel < 95)
                    dt = $urandom_range(0, 8000);
                else
                    dt = $urandom;
                stamp = stamp + dt;

                ev           = '0;
                ev.now_ms    = stamp;
                ev.wheel_dir = 8'($urandom);
                sel = $urandom_range(0, 99);
                if (sel < 10)
                begin
                    ev.cmd         = CMD_WHEEL;
                    ev.event_x     = 16'($urandom);
                    ev.event_y     = 16'($urandom);
                    ev.button_code = 3'($urandom);
                    ev.button_down = 1'($urandom);
                end
                else
                begin
                    ev.cmd = CMD_POINTER;
                    sel = $urandom_range(0, 99);
                    if (sel < 10)
                    begin
                        ev.event_x = 16'($urandom);
                        ev.event_y = 16'($urandom);
                    end
                    else if (sel < 35)
                    begin
                        ev.event_x = 16'(trk_x);
                        ev.event_y = 16'(trk_y);
                    end
                    else
                    begin
                        ev.event_x = 16'(int'(trk_x) + int'($urandom_range(0, 8)) - 4);
                        ev.event_y = 16'(int'(trk_y) + int'($urandom_range(0, 8)) - 4);
                    end

                    // keep the same button half the time to form press/release runs
                    if ($urandom_range(0, 1) == 0)
                    begin
                        sel = $urandom_range(0, 9);
                        if (sel < 8)
                            pick_code = 3'($urandom_range(BTN_LEFT, BTN_EXTRA2));
                        else if (sel == 8)
                            pick_code = BTN_NONE;
                        else
                            pick_code = 3'($urandom_range(BTN_UNUSED_A, BTN_UNUSED_B));
                    end
                    ev.button_code = pick_code;
                    ev.button_down = ($urandom_range(0, 99) < 60);
                end
                send_event(ev, 1'b0, '0);
            end
        end

        settle();

        $display("%0d events checked as %0d reports over %0d register writes",
                 n_events, n_reports, n_writes);
        $display("saw %0d clicks, %0d double clicks, %0d holds, %0d inactive reports",
                 n_clicks, n_doubles, n_holds, n_inactive);
        if (n_errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> pointer_tracker_click_detector.f
hdl/ptcd_pkg.sv
hdl/ptcd_regs.sv
hdl/ptcd_core.sv
hdl/pointer_tracker_click_detector.sv
tb/testbench.sv
